// File: rtl/core/three_key_debounce_long_press_defines.svh
// assertion macros for the three key debouncer
`ifndef THREE_KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define THREE_KEY_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TKD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tkd same-cycle check failed");

// next-cycle implication, checked outside reset
`define TKD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tkd next-cycle check failed");

`endif

// File: rtl/core/tkd_pkg.sv
`timescale 1ns / 1ps

package tkd_pkg;

    // width of the wrapping millisecond counter used for elapsed time
    localparam int TIME_BITS = 32;

    localparam int THR_BITS = 16;

    // register reset values
    localparam logic [THR_BITS-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [THR_BITS-1:0] LONG_PRESS_RESET = 16'd1000;

    // register indexes
    typedef enum logic {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } t_reg_index;

    // result codes
    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_UP         = 3'd1,
        EV_DOWN       = 3'd2,
        EV_MODE_SHORT = 3'd3,
        EV_MODE_LONG  = 3'd4
    } t_key_event;

    // reports from the mode key tracker
    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_mode_rpt;

endpackage

// File: rtl/core/tkd_key.sv
`timescale 1ns / 1ps

module tkd_key (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic                             i_pressed,
    input  logic [tkd_pkg::TIME_BITS-1:0]    i_now,
    input  logic [tkd_pkg::THR_BITS-1:0]     i_debounce,
    output logic                             o_report
);

    logic                          r_held;
    logic                          r_done;
    logic [tkd_pkg::TIME_BITS-1:0] r_start;
    logic [tkd_pkg::TIME_BITS-1:0] w_elapsed;
    logic                          w_due;

    // modulo elapsed time since the press edge
    assign w_elapsed = i_now - r_start;
    assign w_due     = w_elapsed >= tkd_pkg::TIME_BITS'(i_debounce);
    assign o_report  = i_pressed && r_held && !r_done && w_due;

    // held / done flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_done <= 1'b0;
        end else if (i_advance) begin
            if (i_pressed) begin
                if (!r_held) begin
                    r_held <= 1'b1;
                    r_done <= 1'b0;
                end else if (o_report) begin
                    r_done <= 1'b1;
                end
            end else begin
                r_held <= 1'b0;
                r_done <= 1'b0;
            end
        end
    end

    // press timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_advance && i_pressed && !r_held) begin
            r_start <= i_now;
        end
    end

endmodule

// File: rtl/core/tkd_mode.sv
`timescale 1ns / 1ps

module tkd_mode (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_advance,
    input  logic                             i_pressed,
    input  logic [tkd_pkg::TIME_BITS-1:0]    i_now,
    input  logic [tkd_pkg::THR_BITS-1:0]     i_debounce,
    input  logic [tkd_pkg::THR_BITS-1:0]     i_long_press,
    output tkd_pkg::t_mode_rpt               o_rpt
);

    logic                          r_held;
    logic                          r_done;
    logic [tkd_pkg::TIME_BITS-1:0] r_start;
    logic [tkd_pkg::TIME_BITS-1:0] w_elapsed;
    logic                          w_past_debounce;
    logic                          w_past_long;

    // elapsed time and threshold compares
    assign w_elapsed       = i_now - r_start;
    assign w_past_debounce = w_elapsed >= tkd_pkg::TIME_BITS'(i_debounce);
    assign w_past_long     = w_elapsed >= tkd_pkg::TIME_BITS'(i_long_press);

    // long while still held, short on release
    assign o_rpt.long_press  = i_pressed && r_held && !r_done && w_past_long;
    assign o_rpt.short_press = !i_pressed && r_held && !r_done
                               && w_past_debounce && !w_past_long;

    // held / done flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_done <= 1'b0;
        end else if (i_advance) begin
            if (i_pressed) begin
                if (!r_held) begin
                    r_held <= 1'b1;
                    r_done <= 1'b0;
                end else if (o_rpt.long_press) begin
                    r_done <= 1'b1;
                end
            end else begin
                r_held <= 1'b0;
                r_done <= 1'b0;
            end
        end
    end

    // press timestamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
        end else if (i_advance && i_pressed && !r_held) begin
            r_start <= i_now;
        end
    end

endmodule

// File: rtl/core/three_key_debounce_long_press.sv
`timescale 1ns / 1ps
// channel | direction | handshake                  | payload
// in      | input     | i_in_valid / o_in_stall    | i_now_ms, i_up_level, i_down_level,
//         |           |                            | i_mode_level
// out     | output    | o_out_valid / i_out_stall  | o_key_event
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one scan per cycle unless the output stalls; a request reaches o_key_event through
// the input register, loaded at its accepting edge, and then the result register
// synchronous active-low reset clears key flags, start times and valids;
// thresholds return to 50 ms and 1000 ms
// a stalled result holds; the input register still takes one more request,
// and o_in_stall rises only when both registers are full and the output is stalled

`include "three_key_debounce_long_press_defines.svh"

module three_key_debounce_long_press (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_now_ms,
    input  logic        i_up_level,
    input  logic        i_down_level,
    input  logic        i_mode_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_key_event,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic                          r_s1_valid;
    logic [tkd_pkg::TIME_BITS-1:0] r_now;
    logic                          r_up_p;
    logic                          r_down_p;
    logic                          r_mode_p;
    logic                          r_out_valid;
    tkd_pkg::t_key_event           r_event;
    tkd_pkg::t_key_event           n_event;
    logic [tkd_pkg::THR_BITS-1:0]  r_debounce;
    logic [tkd_pkg::THR_BITS-1:0]  r_long_press;
    logic                          w_advance;
    logic                          w_accept;
    logic                          w_up_rpt;
    logic                          w_down_rpt;
    tkd_pkg::t_mode_rpt            w_mode_rpt;

    // handshake
    assign w_advance   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !w_advance;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_key_event = r_event;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= tkd_pkg::DEBOUNCE_RESET;
            r_long_press <= tkd_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (tkd_pkg::t_reg_index'(i_cfg_index))
                tkd_pkg::REG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                tkd_pkg::REG_LONG_PRESS: r_long_press <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input register payload, levels turned into pressed flags
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now    <= tkd_pkg::TIME_BITS'(i_now_ms);
            r_up_p   <= !i_up_level;
            r_down_p <= !i_down_level;
            r_mode_p <= !i_mode_level;
        end
    end

    // per-key trackers
    tkd_key u_up (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_pressed  (r_up_p),
        .i_now      (r_now),
        .i_debounce (r_debounce),
        .o_report   (w_up_rpt)
    );

    tkd_key u_down (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_pressed  (r_down_p),
        .i_now      (r_now),
        .i_debounce (r_debounce),
        .o_report   (w_down_rpt)
    );

    tkd_mode u_mode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_pressed    (r_mode_p),
        .i_now        (r_now),
        .i_debounce   (r_debounce),
        .i_long_press (r_long_press),
        .o_rpt        (w_mode_rpt)
    );

    // priority: mode over down over up
    always_comb begin
        if (w_mode_rpt.long_press) begin
            n_event = tkd_pkg::EV_MODE_LONG;
        end else if (w_mode_rpt.short_press) begin
            n_event = tkd_pkg::EV_MODE_SHORT;
        end else if (w_down_rpt) begin
            n_event = tkd_pkg::EV_DOWN;
        end else if (w_up_rpt) begin
            n_event = tkd_pkg::EV_UP;
        end else begin
            n_event = tkd_pkg::EV_NONE;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_event <= n_event;
        end
    end

    // checks
    `TKD_ASSERT_IMP(a_stall_only_full, o_in_stall, r_s1_valid && r_out_valid && i_out_stall)
    `TKD_ASSERT_NXT(a_advance_gives_result, w_advance, r_out_valid && r_event == $past(n_event))
    `TKD_ASSERT_IMP(a_mode_one_report, w_advance,
        !(w_mode_rpt.long_press && w_mode_rpt.short_press))
    `TKD_ASSERT_NXT(a_held_result_stays, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_event))

endmodule
